FILE: rtl/core/ctrv_pkg.sv
// shared widths, fixed-point constants and the cordic arctangent table
// for the ctrv motion prediction pipeline; no dependencies
package ctrv_pkg;

  localparam int DATA_W    = 32;  // signed q16.16 payload
  localparam int DT_W      = 24;  // unsigned q8.16 time step
  localparam int EPS_W     = 16;  // turn rate threshold
  localparam int CFG_IDX_W = 4;

  localparam int ANG_W     = 42;  // heading plus turn over one step
  localparam int RW        = 20;  // reduced angle, q4.16
  localparam int RED_STEPS = 22;  // restoring steps of the 2pi reduction
  localparam int CORD_W    = 34;  // cordic datapath, q2.30 plus margin
  localparam int SC_W      = 26;  // sine / cosine in q4.22
  localparam int NUM_W     = 59;  // speed times trig difference

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int TWO_PI_Q16  = 411775;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_DELTA_TIME = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_EPS    = 4'd1;

  localparam logic [DT_W-1:0]  DELTA_TIME_RST = 24'd6554;
  localparam logic [EPS_W-1:0] YAW_EPS_RST    = 16'd66;

  localparam logic signed [CORD_W-1:0] ATAN_HEAD [0:9] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516,  34'sd16775851,  34'sd8388437,   34'sd4194283,   34'sd2097149
  };

  // atan(2^-i) in q2.30; exact powers of two from index 10 on
  function automatic logic signed [CORD_W-1:0] atan_q30(input int idx);
    logic signed [CORD_W-1:0] val;
    if (idx < 10) begin
      val = ATAN_HEAD[4'(idx)];
    end else if (idx <= 30) begin
      val = CORD_W'(1) << (30 - idx);
    end else begin
      val = '0;
    end
    return val;
  endfunction

endpackage

FILE: rtl/core/ctrv_sincos.sv
// pipelined sine/cosine: 2pi reduction by restoring steps, quadrant fold,
// then one cordic rotation per stage; depends on ctrv_pkg
module ctrv_sincos #(
  parameter int STEPS = ctrv_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [ctrv_pkg::ANG_W-1:0]  in_angle,
  output logic                               out_vld,
  output logic signed [ctrv_pkg::SC_W-1:0]   out_sin,
  output logic signed [ctrv_pkg::SC_W-1:0]   out_cos
);
  import ctrv_pkg::*;

  logic [ANG_W-1:0]         red_mag_r [0:RED_STEPS];
  logic                     red_neg_r [0:RED_STEPS];
  logic                     red_vld_r [0:RED_STEPS];
  logic signed [RW-1:0]     fix_r, fix_nxt;
  logic                     fix_vld_r;
  logic signed [RW-1:0]     fold_nxt;
  logic                     fold_neg_nxt;
  logic signed [CORD_W-1:0] cx_r [0:STEPS];
  logic signed [CORD_W-1:0] cy_r [0:STEPS];
  logic signed [CORD_W-1:0] cz_r [0:STEPS];
  logic                     cneg_r [0:STEPS];
  logic                     cvld_r [0:STEPS];
  logic signed [CORD_W-1:0] cos_full;
  logic signed [SC_W-1:0]   out_sin_r, out_cos_r;
  logic                     out_vld_r;
  logic signed [RW-1:0]     rm, r0;

  function automatic logic [ANG_W-1:0] red_sub(input int k);
    return ANG_W'(TWO_PI_Q16) << (RED_STEPS - 1 - k);
  endfunction

  // magnitude mod 2pi back to a floor modulo, then into (-pi, pi]
  always_comb begin
    rm = $signed(red_mag_r[RED_STEPS][RW-1:0]);
    if (red_neg_r[RED_STEPS] && rm != '0) begin
      r0 = RW'(TWO_PI_Q16) - rm;
    end else begin
      r0 = rm;
    end
    if (r0 > PI_Q16) begin
      fix_nxt = r0 - RW'(TWO_PI_Q16);
    end else begin
      fix_nxt = r0;
    end
  end

  always_comb begin
    if (fix_r > HALF_PI_Q16) begin
      fold_nxt     = RW'(PI_Q16) - fix_r;
      fold_neg_nxt = 1'b1;
    end else if (fix_r < -HALF_PI_Q16) begin
      fold_nxt     = -RW'(PI_Q16) - fix_r;
      fold_neg_nxt = 1'b1;
    end else begin
      fold_nxt     = fix_r;
      fold_neg_nxt = 1'b0;
    end
  end

  assign cos_full = cneg_r[STEPS] ? -cx_r[STEPS] : cx_r[STEPS];

  always_ff @(posedge clk) begin
    red_mag_r[0] <= in_angle[ANG_W-1] ? ANG_W'(-in_angle) : ANG_W'(in_angle);
    red_neg_r[0] <= in_angle[ANG_W-1];
    for (int k = 0; k < RED_STEPS; k++) begin
      if (red_mag_r[k] >= red_sub(k)) begin
        red_mag_r[k+1] <= red_mag_r[k] - red_sub(k);
      end else begin
        red_mag_r[k+1] <= red_mag_r[k];
      end
      red_neg_r[k+1] <= red_neg_r[k];
    end
    fix_r     <= fix_nxt;
    cx_r[0]   <= CORDIC_GAIN_Q30;
    cy_r[0]   <= '0;
    cz_r[0]   <= CORD_W'(fold_nxt) <<< 14;
    cneg_r[0] <= fold_neg_nxt;
    for (int i = 0; i < STEPS; i++) begin
      if (cz_r[i][CORD_W-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + atan_q30(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - atan_q30(i);
      end
      cneg_r[i+1] <= cneg_r[i];
    end
    out_sin_r <= SC_W'(cy_r[STEPS] >>> 8);
    out_cos_r <= SC_W'(cos_full >>> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_vld_r <= '{default: 1'b0};
      fix_vld_r <= 1'b0;
      cvld_r    <= '{default: 1'b0};
      out_vld_r <= 1'b0;
    end else begin
      red_vld_r[0] <= in_vld;
      for (int k = 0; k < RED_STEPS; k++) begin
        red_vld_r[k+1] <= red_vld_r[k];
      end
      fix_vld_r <= red_vld_r[RED_STEPS];
      cvld_r[0] <= fix_vld_r;
      for (int i = 0; i < STEPS; i++) begin
        cvld_r[i+1] <= cvld_r[i];
      end
      out_vld_r <= cvld_r[STEPS];
    end
  end

  assign out_vld = out_vld_r;
  assign out_sin = out_sin_r;
  assign out_cos = out_cos_r;

  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    red_vld_r[RED_STEPS] |-> red_mag_r[RED_STEPS] < ANG_W'(TWO_PI_Q16))
    else $error("angle reduction left a remainder of 2pi or more");

  a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
    fix_vld_r |-> (fix_r <= PI_Q16 && fix_r >= -PI_Q16))
    else $error("reduced angle outside [-pi, pi]");

endmodule

FILE: rtl/core/ctrv_div.sv
// pipelined signed divide, quotient truncated toward zero, one restoring
// step per stage; depends on ctrv_pkg
module ctrv_div #(
  parameter int NW = ctrv_pkg::NUM_W,
  parameter int DW = ctrv_pkg::DATA_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic signed [NW-1:0] in_num,
  input  logic signed [DW-1:0] in_den,
  output logic                out_vld,
  output logic signed [NW:0]  out_quo
);
  import ctrv_pkg::*;

  logic [DW-1:0]    rem_r [0:NW];
  logic [NW-1:0]    nq_r  [0:NW];
  logic [DW-1:0]    den_r [0:NW];
  logic             sgn_r [0:NW];
  logic             vld_r [0:NW];
  logic signed [NW:0] quo_r;
  logic             quo_vld_r;

  function automatic logic [DW:0] trial(input logic [DW-1:0] rem, input logic nb);
    return {rem, nb};
  endfunction

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
    den_r[0] <= in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
    sgn_r[0] <= in_num[NW-1] ^ in_den[DW-1];
    for (int k = 0; k < NW; k++) begin
      // numerator shifts out at the top while quotient bits shift in below
      if (trial(rem_r[k], nq_r[k][NW-1]) >= {1'b0, den_r[k]}) begin
        rem_r[k+1] <= DW'(trial(rem_r[k], nq_r[k][NW-1]) - {1'b0, den_r[k]});
        nq_r[k+1]  <= {nq_r[k][NW-2:0], 1'b1};
      end else begin
        rem_r[k+1] <= DW'(trial(rem_r[k], nq_r[k][NW-1]));
        nq_r[k+1]  <= {nq_r[k][NW-2:0], 1'b0};
      end
      den_r[k+1] <= den_r[k];
      sgn_r[k+1] <= sgn_r[k];
    end
    quo_r <= sgn_r[NW] ? -$signed({1'b0, nq_r[NW]}) : $signed({1'b0, nq_r[NW]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '{default: 1'b0};
      quo_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < NW; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      quo_vld_r <= vld_r[NW];
    end
  end

  assign out_vld = quo_vld_r;
  assign out_quo = quo_r;

endmodule

FILE: rtl/core/ctrv_particle_motion_predict_top.sv
// ctrv particle motion prediction: pose advance over one time step plus noise
// uses ctrv_pkg, ctrv_sincos (heading and heading+turn) and ctrv_div (x and y)
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   request  | in_pose_x .. in_final_particle          | start && !busy
//   result   | out_new_x .. out_final_out              | out_strobe, one cycle
//   config   | cfg_index, cfg_wdata                    | cfg_we
//
// one request per cycle; busy stays low
// the result strobe follows the accepting edge through the 22-step 2pi reduction
// and the cordic in ctrv_sincos, then the 59-step divider, whose quotient is taken
// in the turning case
// reset clears valid bits and restores delta_time and yaw_epsilon
// no stall: every stage advances each cycle
module ctrv_particle_motion_predict_top #(
  parameter int CORDIC_STEPS = ctrv_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_pose_x,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_pose_y,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_heading,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_speed,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_turn_rate,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_noise_x,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_noise_y,
  input  logic signed [ctrv_pkg::DATA_W-1:0]    in_noise_heading,
  input  logic                                  in_final_particle,
  output logic                                  out_strobe,
  output logic signed [ctrv_pkg::DATA_W-1:0]    out_new_x,
  output logic signed [ctrv_pkg::DATA_W-1:0]    out_new_y,
  output logic signed [ctrv_pkg::DATA_W-1:0]    out_new_heading,
  output logic                                  out_final_out,
  input  logic                                  cfg_we,
  input  logic [ctrv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctrv_pkg::DT_W-1:0]             cfg_wdata
);
  import ctrv_pkg::*;

  localparam int PROD_W  = DATA_W + DT_W + 1;
  localparam int D_W     = PROD_W - 16;
  localparam int HS_W    = ANG_W + 1;
  localparam int SX_W    = D_W + SC_W - 22;
  localparam int DX_W    = NUM_W + 1 - 6;
  localparam int SUM_W   = DX_W + 2;
  localparam int SC_LAT  = CORDIC_STEPS + RED_STEPS + 4;
  localparam int DIV_LAT = NUM_W + 2;
  localparam int TOT_LAT = SC_LAT + DIV_LAT + 7;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [HS_W-1:0]   hs;
    logic signed [D_W-1:0]    d;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] w;
    logic                     fin;
    logic                     straight;
  } sc_side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [HS_W-1:0]   hs;
    logic signed [SX_W-1:0]   sx;
    logic signed [SX_W-1:0]   sy;
    logic                     fin;
    logic                     straight;
  } dv_side_t;

  logic [DT_W-1:0]  dt_r;
  logic [EPS_W-1:0] eps_r;

  // stage a: captured request
  logic                     a_vld_r, a_fin_r;
  logic signed [DATA_W-1:0] a_px_r, a_py_r, a_hd_r, a_v_r, a_w_r, a_nx_r, a_ny_r, a_nh_r;
  // stage b: time step products
  logic                     b_vld_r, b_fin_r, b_straight_r, straight_nxt;
  logic signed [PROD_W-1:0] b_prodw_r, b_prodv_r;
  logic signed [DATA_W-1:0] b_px_r, b_py_r, b_hd_r, b_v_r, b_w_r, b_nx_r, b_ny_r, b_nh_r;
  logic [DATA_W:0]          aw_mag;
  // stage c: angles
  logic                     c_vld_r;
  logic signed [ANG_W-1:0]  c_tp_r, c_hd_r;
  sc_side_t                 c_side_r;
  sc_side_t                 sc_line_r [0:SC_LAT-1];
  logic                     sc_h_vld, sc_t_vld;
  logic signed [SC_W-1:0]   s0, c0, s1, c1;
  // stage e: trig differences
  logic                     e_vld_r;
  logic signed [SC_W:0]     e_ds_r, e_dc_r;
  logic signed [SC_W-1:0]   e_s0_r, e_c0_r;
  sc_side_t                 e_side_r;
  // stage f: products
  logic                     f_vld_r;
  logic signed [NUM_W-1:0]  f_numx_r, f_numy_r;
  logic signed [DATA_W-1:0] f_w_r;
  dv_side_t                 f_side_r;
  dv_side_t                 dv_line_r [0:DIV_LAT-1];
  logic                     dvx_vld, dvy_vld;
  logic signed [NUM_W:0]    quo_x, quo_y;
  dv_side_t                 dv_side;
  // stage g: displacement select
  logic                     g_vld_r, g_fin_r;
  logic signed [DX_W-1:0]   g_dx_r, g_dy_r;
  logic signed [DATA_W-1:0] g_px_r, g_py_r, g_nx_r, g_ny_r;
  logic signed [HS_W-1:0]   g_hs_r;
  // stage h: results
  logic                     out_strobe_r, out_final_r;
  logic signed [DATA_W-1:0] out_x_r, out_y_r, out_h_r;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] val);
    logic signed [DATA_W-1:0] res;
    if (val > $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (val < -$signed(SUM_W'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = DATA_W'(val);
    end
    return res;
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r  <= DELTA_TIME_RST;
      eps_r <= YAW_EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELTA_TIME: dt_r  <= cfg_wdata;
        REG_YAW_EPS:    eps_r <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    aw_mag       = a_w_r[DATA_W-1] ? (DATA_W+1)'(-(DATA_W+1)'(a_w_r)) : (DATA_W+1)'(a_w_r);
    straight_nxt = aw_mag <= (DATA_W+1)'(eps_r);
  end

  assign dv_side = dv_line_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    a_px_r  <= in_pose_x;
    a_py_r  <= in_pose_y;
    a_hd_r  <= in_heading;
    a_v_r   <= in_speed;
    a_w_r   <= in_turn_rate;
    a_nx_r  <= in_noise_x;
    a_ny_r  <= in_noise_y;
    a_nh_r  <= in_noise_heading;
    a_fin_r <= in_final_particle;

    b_prodw_r    <= a_w_r * $signed({1'b0, dt_r});
    b_prodv_r    <= a_v_r * $signed({1'b0, dt_r});
    b_straight_r <= straight_nxt;
    b_px_r <= a_px_r;  b_py_r <= a_py_r;  b_hd_r <= a_hd_r;
    b_v_r  <= a_v_r;   b_w_r  <= a_w_r;
    b_nx_r <= a_nx_r;  b_ny_r <= a_ny_r;  b_nh_r <= a_nh_r;
    b_fin_r <= a_fin_r;

    c_tp_r            <= ANG_W'(b_hd_r) + ANG_W'(b_prodw_r >>> 16);
    c_hd_r            <= ANG_W'(b_hd_r);
    c_side_r.px       <= b_px_r;
    c_side_r.py       <= b_py_r;
    c_side_r.nx       <= b_nx_r;
    c_side_r.ny       <= b_ny_r;
    c_side_r.hs       <= HS_W'(b_hd_r) + HS_W'(b_prodw_r >>> 16) + HS_W'(b_nh_r);
    c_side_r.d        <= D_W'(b_prodv_r >>> 16);
    c_side_r.v        <= b_v_r;
    c_side_r.w        <= b_w_r;
    c_side_r.fin      <= b_fin_r;
    c_side_r.straight <= b_straight_r;

    sc_line_r[0] <= c_side_r;
    for (int k = 1; k < SC_LAT; k++) begin
      sc_line_r[k] <= sc_line_r[k-1];
    end

    e_ds_r   <= (SC_W+1)'(s1) - (SC_W+1)'(s0);
    e_dc_r   <= (SC_W+1)'(c0) - (SC_W+1)'(c1);
    e_s0_r   <= s0;
    e_c0_r   <= c0;
    e_side_r <= sc_line_r[SC_LAT-1];

    f_numx_r          <= e_side_r.v * e_ds_r;
    f_numy_r          <= e_side_r.v * e_dc_r;
    f_w_r             <= e_side_r.w;
    f_side_r.px       <= e_side_r.px;
    f_side_r.py       <= e_side_r.py;
    f_side_r.nx       <= e_side_r.nx;
    f_side_r.ny       <= e_side_r.ny;
    f_side_r.hs       <= e_side_r.hs;
    // full product width before the shift
    f_side_r.sx       <= SX_W'((D_W+SC_W)'(e_side_r.d * e_c0_r) >>> 22);
    f_side_r.sy       <= SX_W'((D_W+SC_W)'(e_side_r.d * e_s0_r) >>> 22);
    f_side_r.fin      <= e_side_r.fin;
    f_side_r.straight <= e_side_r.straight;

    dv_line_r[0] <= f_side_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      dv_line_r[k] <= dv_line_r[k-1];
    end

    // small turn rate takes the straight-line displacement
    if (dv_side.straight) begin
      g_dx_r <= DX_W'(dv_side.sx);
      g_dy_r <= DX_W'(dv_side.sy);
    end else begin
      g_dx_r <= DX_W'(quo_x >>> 6);
      g_dy_r <= DX_W'(quo_y >>> 6);
    end
    g_px_r  <= dv_side.px;
    g_py_r  <= dv_side.py;
    g_nx_r  <= dv_side.nx;
    g_ny_r  <= dv_side.ny;
    g_hs_r  <= dv_side.hs;
    g_fin_r <= dv_side.fin;

    out_x_r     <= sat32(SUM_W'(g_px_r) + SUM_W'(g_dx_r) + SUM_W'(g_nx_r));
    out_y_r     <= sat32(SUM_W'(g_py_r) + SUM_W'(g_dy_r) + SUM_W'(g_ny_r));
    out_h_r     <= sat32(SUM_W'(g_hs_r));
    out_final_r <= g_fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      e_vld_r      <= 1'b0;
      f_vld_r      <= 1'b0;
      g_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      a_vld_r      <= start && !busy;
      b_vld_r      <= a_vld_r;
      c_vld_r      <= b_vld_r;
      e_vld_r      <= sc_h_vld;
      f_vld_r      <= e_vld_r;
      g_vld_r      <= dvx_vld;
      out_strobe_r <= g_vld_r;
    end
  end

  ctrv_sincos #(.STEPS(CORDIC_STEPS)) u_sincos_hd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_angle (c_hd_r),
    .out_vld  (sc_h_vld),
    .out_sin  (s0),
    .out_cos  (c0)
  );

  ctrv_sincos #(.STEPS(CORDIC_STEPS)) u_sincos_tp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_angle (c_tp_r),
    .out_vld  (sc_t_vld),
    .out_sin  (s1),
    .out_cos  (c1)
  );

  ctrv_div #(.NW(NUM_W), .DW(DATA_W)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld_r),
    .in_num  (f_numx_r),
    .in_den  (f_w_r),
    .out_vld (dvx_vld),
    .out_quo (quo_x)
  );

  ctrv_div #(.NW(NUM_W), .DW(DATA_W)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld_r),
    .in_num  (f_numy_r),
    .in_den  (f_w_r),
    .out_vld (dvy_vld),
    .out_quo (quo_y)
  );

  assign out_strobe      = out_strobe_r;
  assign out_new_x       = out_x_r;
  assign out_new_y       = out_y_r;
  assign out_new_heading = out_h_r;
  assign out_final_out   = out_final_r;

  a_trig_lat: assert property (@(posedge clk) disable iff (!rst_n)
    sc_h_vld |-> $past(c_vld_r, SC_LAT))
    else $error("sincos latency does not match the side data line");

  a_trig_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sc_h_vld == sc_t_vld)
    else $error("heading and turned heading trig out of step");

  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (dvx_vld == dvy_vld) && (!dvx_vld || $past(f_vld_r, DIV_LAT)))
    else $error("divider latency does not match the side data line");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, TOT_LAT))
    else $error("result strobe without a matching request");

endmodule
